// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tsa_pkg.sv
`timescale 1ns / 1ps

package tsa_pkg;

    localparam int COORD_BITS   = 12;
    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TWIRL_GAIN   = 3;

    // down shift from q30 tables to the working fraction
    localparam int DSHIFT    = 30 - FRAC_BITS;
    localparam int D_W       = COORD_BITS + 1;
    localparam int SQ_W      = 2 * COORD_BITS + 2;
    localparam int ROOT_BITS = COORD_BITS + FRAC_BITS + 1;
    localparam int REM_W     = ROOT_BITS + 2;
    localparam int XY_W      = COORD_BITS + FRAC_BITS + 6;
    localparam int ANG_W     = FRAC_BITS + 6;
    localparam int Q_BITS    = FRAC_BITS + 3;
    localparam int NUM_W     = COORD_BITS + FRAC_BITS + 4;
    localparam int R_W       = COORD_BITS + 1;
    localparam int IDX_W     = 2 * COORD_BITS;
    localparam int NX_W      = XY_W + 1 - FRAC_BITS;
    localparam int ADDR_W    = 5;

    localparam logic [30:0] K_Q30       = 31'h26DD3B6A;
    localparam logic [31:0] HALF_PI_Q30 = 32'h6487ED51;

    localparam logic signed [ANG_W-1:0] HALF_PI = ANG_W'(HALF_PI_Q30 >> DSHIFT);
    localparam logic signed [ANG_W-1:0] ANG_SAT = ANG_W'(TWIRL_GAIN << FRAC_BITS);

    localparam logic [31:0] ATAN_Q30 [24] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // register indexes on the config port
    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CX     = 3'd2;
    localparam logic [2:0] REG_CY     = 3'd3;
    localparam logic [2:0] REG_RADIUS = 3'd4;
    localparam logic [2:0] REG_RSQ    = 3'd5;

    typedef struct packed {
        logic                         in_disc;
        logic [COORD_BITS-1:0]        px;
        logic [COORD_BITS-1:0]        py;
        logic signed [XY_W-1:0]       x;
        logic signed [XY_W-1:0]       y;
    } side_t;

    function automatic logic signed [ANG_W-1:0] atan_step(input int i);
        return ANG_W'(ATAN_Q30[i] >> DSHIFT);
    endfunction

endpackage

// File: src/twirl_source_address_top.sv
`timescale 1ns / 1ps

// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------
// pixel in  | in_valid / in_stall  | pixel_x, pixel_y
// source out| out_valid / out_stall| remapped, source_x, source_y, source_index
// config    | apb psel / penable   | paddr, pwdata, prdata
//
// one pixel per clock unless the output stalls; the pipeline depth is set by
// the bit-per-stage square root, the bit-per-stage angle divider and the
// cordic rotation stages. reset clears all valid bits and loads the register
// defaults. a stall on the output freezes every stage at once, so nothing is
// lost or repeated; in_stall follows out_stall while the last stage is full.

`include "assert_macros.svh"

module twirl_source_address_top
    import tsa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  remapped,
    output logic [COORD_BITS-1:0] source_x,
    output logic [COORD_BITS-1:0] source_y,
    output logic [IDX_W-1:0]      source_index
);

    logic [R_W-1:0]        image_width_reg;
    logic [R_W-1:0]        image_height_reg;
    logic [COORD_BITS-1:0] center_x_reg;
    logic [COORD_BITS-1:0] center_y_reg;
    logic [R_W-1:0]        twirl_radius_reg;
    logic [24:0]           radius_squared_reg;

    logic       en;
    logic [2:0] reg_sel;

    assign en       = !(out_valid && out_stall);
    assign in_stall = out_valid && out_stall;
    assign pready   = 1'b1;
    assign reg_sel  = paddr[ADDR_W-1:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= 13'd1024;
            image_height_reg   <= 13'd1024;
            center_x_reg       <= 12'd512;
            center_y_reg       <= 12'd512;
            twirl_radius_reg   <= 13'd512;
            radius_squared_reg <= 25'd262144;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_WIDTH:  image_width_reg    <= pwdata[R_W-1:0];
                REG_HEIGHT: image_height_reg   <= pwdata[R_W-1:0];
                REG_CX:     center_x_reg       <= pwdata[COORD_BITS-1:0];
                REG_CY:     center_y_reg       <= pwdata[COORD_BITS-1:0];
                REG_RADIUS: twirl_radius_reg   <= pwdata[R_W-1:0];
                REG_RSQ:    radius_squared_reg <= pwdata[24:0];
                default:    ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_sel)
            REG_WIDTH:  prdata = 32'(image_width_reg);
            REG_HEIGHT: prdata = 32'(image_height_reg);
            REG_CX:     prdata = 32'(center_x_reg);
            REG_CY:     prdata = 32'(center_y_reg);
            REG_RADIUS: prdata = 32'(twirl_radius_reg);
            REG_RSQ:    prdata = 32'(radius_squared_reg);
            default:    prdata = '0;
        endcase
    end

    // offsets from the centre
    logic                  vld1_reg;
    logic signed [D_W-1:0] dx_reg;
    logic signed [D_W-1:0] dy_reg;
    logic [COORD_BITS-1:0] px1_reg;
    logic [COORD_BITS-1:0] py1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld1_reg <= 1'b0;
        else if (en)
            vld1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= $signed({1'b0, pixel_x}) - $signed({1'b0, center_x_reg});
            dy_reg  <= $signed({1'b0, pixel_y}) - $signed({1'b0, center_y_reg});
            px1_reg <= pixel_x;
            py1_reg <= pixel_y;
        end
    end

    // squares and gain-compensated start vector
    logic signed [SQ_W-1:0]   sqx;
    logic signed [SQ_W-1:0]   sqy;
    logic signed [D_W+31:0]   kx;
    logic signed [D_W+31:0]   ky;
    logic                     vld2_reg;
    logic [SQ_W-1:0]          sqx_reg;
    logic [SQ_W-1:0]          sqy_reg;
    logic signed [XY_W-1:0]   x0_reg;
    logic signed [XY_W-1:0]   y0_reg;
    logic [COORD_BITS-1:0]    px2_reg;
    logic [COORD_BITS-1:0]    py2_reg;

    assign sqx = dx_reg * dx_reg;
    assign sqy = dy_reg * dy_reg;
    assign kx  = dx_reg * $signed({1'b0, K_Q30});
    assign ky  = dy_reg * $signed({1'b0, K_Q30});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld2_reg <= 1'b0;
        else if (en)
            vld2_reg <= vld1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= $unsigned(sqx);
            sqy_reg <= $unsigned(sqy);
            x0_reg  <= XY_W'(kx >>> DSHIFT);
            y0_reg  <= XY_W'(ky >>> DSHIFT);
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
        end
    end

    // squared distance and disc test
    logic [SQ_W-1:0] dist2_sum;
    logic            vld3_reg;
    logic [SQ_W-1:0] dist2_reg;
    side_t           side3_reg;

    assign dist2_sum = sqx_reg + sqy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld3_reg <= 1'b0;
        else if (en)
            vld3_reg <= vld2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist2_reg         <= dist2_sum;
            side3_reg.in_disc <= dist2_sum <= SQ_W'(radius_squared_reg);
            side3_reg.px      <= px2_reg;
            side3_reg.py      <= py2_reg;
            side3_reg.x       <= x0_reg;
            side3_reg.y       <= y0_reg;
        end
    end

    logic                    root_valid;
    logic [ROOT_BITS-1:0]    root_d;
    side_t                   root_side;
    logic                    div_valid;
    logic signed [ANG_W-1:0] div_ang;
    side_t                   div_side;
    logic                    rot_valid;
    side_t                   rot_side;

    tsa_root u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld3_reg),
        .dist2     (dist2_reg),
        .side_in   (side3_reg),
        .out_valid (root_valid),
        .root      (root_d),
        .side_out  (root_side)
    );

    tsa_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (root_valid),
        .root         (root_d),
        .side_in      (root_side),
        .twirl_radius (twirl_radius_reg),
        .out_valid    (div_valid),
        .ang          (div_ang),
        .side_out     (div_side)
    );

    tsa_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .ang       (div_ang),
        .side_in   (div_side),
        .out_valid (rot_valid),
        .side_out  (rot_side)
    );

    // back to integer coordinates, truncated toward zero
    logic signed [XY_W:0]  vx;
    logic signed [XY_W:0]  vy;
    logic [XY_W:0]         ax;
    logic [XY_W:0]         ay;
    logic signed [XY_W:0]  shx;
    logic signed [XY_W:0]  shy;
    logic                  vld4_reg;
    logic signed [NX_W-1:0] nx_reg;
    logic signed [NX_W-1:0] ny_reg;
    logic                  in4_reg;
    logic [COORD_BITS-1:0] px4_reg;
    logic [COORD_BITS-1:0] py4_reg;

    assign vx  = $signed({{(XY_W+1-COORD_BITS-FRAC_BITS){1'b0}}, center_x_reg,
                          {FRAC_BITS{1'b0}}}) + rot_side.x;
    assign vy  = $signed({{(XY_W+1-COORD_BITS-FRAC_BITS){1'b0}}, center_y_reg,
                          {FRAC_BITS{1'b0}}}) + rot_side.y;
    assign ax  = vx[XY_W] ? $unsigned(-vx) : $unsigned(vx);
    assign ay  = vy[XY_W] ? $unsigned(-vy) : $unsigned(vy);
    assign shx = vx[XY_W] ? -$signed(ax >> FRAC_BITS) : $signed(ax >> FRAC_BITS);
    assign shy = vy[XY_W] ? -$signed(ay >> FRAC_BITS) : $signed(ay >> FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld4_reg <= 1'b0;
        else if (en)
            vld4_reg <= rot_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg  <= shx[NX_W-1:0];
            ny_reg  <= shy[NX_W-1:0];
            in4_reg <= rot_side.in_disc;
            px4_reg <= rot_side.px;
            py4_reg <= rot_side.py;
        end
    end

    // bounds check and source select, kept at full width for the index
    logic                  in_bounds;
    logic                  vld5_reg;
    logic                  rem5_reg;
    logic [R_W-1:0]        sx5_reg;
    logic [R_W-1:0]        sy5_reg;

    assign in_bounds = !nx_reg[NX_W-1] && !ny_reg[NX_W-1]
                    && ($unsigned(nx_reg) < NX_W'(image_width_reg))
                    && ($unsigned(ny_reg) < NX_W'(image_height_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld5_reg <= 1'b0;
        else if (en)
            vld5_reg <= vld4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem5_reg <= in4_reg && in_bounds;
            sx5_reg  <= (in4_reg && in_bounds) ? nx_reg[R_W-1:0] : R_W'(px4_reg);
            sy5_reg  <= (in4_reg && in_bounds) ? ny_reg[R_W-1:0] : R_W'(py4_reg);
        end
    end

    // linear index and output register
    logic [IDX_W+R_W-1:0]  idx_full;
    logic                  vld6_reg;
    logic                  remapped_reg;
    logic [COORD_BITS-1:0] source_x_reg;
    logic [COORD_BITS-1:0] source_y_reg;
    logic [IDX_W-1:0]      source_index_reg;

    assign idx_full = sy5_reg * image_width_reg + (IDX_W+R_W)'(sx5_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld6_reg <= 1'b0;
        else if (en)
            vld6_reg <= vld5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            remapped_reg     <= rem5_reg;
            source_x_reg     <= sx5_reg[COORD_BITS-1:0];
            source_y_reg     <= sy5_reg[COORD_BITS-1:0];
            source_index_reg <= idx_full[IDX_W-1:0];
        end
    end

    assign out_valid    = vld6_reg;
    assign remapped     = remapped_reg;
    assign source_x     = source_x_reg;
    assign source_y     = source_y_reg;
    assign source_index = source_index_reg;

    // checks
    `ASSERT_IMPLIES(a_remap_in_image, out_valid && remapped,
        (13'(source_x) < image_width_reg) && (13'(source_y) < image_height_reg),
        "remapped source lies outside the image")
    `ASSERT_NEXT(a_stall_freezes_last, out_valid && out_stall,
        out_valid && $stable(source_index) && $stable(remapped),
        "output stage moved during a stall")
    `ASSERT_IMPLIES(a_no_take_on_stall, out_valid && out_stall, in_stall,
        "pixel taken while output stalled")

endmodule

// File: src/tsa_root.sv
`timescale 1ns / 1ps

module tsa_root
    import tsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [SQ_W-1:0]      dist2,
    input  side_t                side_in,
    output logic                 out_valid,
    output logic [ROOT_BITS-1:0] root,
    output side_t                side_out
);

    logic                 vld_reg  [ROOT_BITS];
    logic [SQ_W-1:0]      n_reg    [ROOT_BITS];
    logic [REM_W-1:0]     rem_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg [ROOT_BITS];
    side_t                side_reg [ROOT_BITS];

    // one root bit per stage, most significant first
    for (genvar i = 0; i < ROOT_BITS; i++) begin : g_stage
        localparam int K = COORD_BITS - i;
        logic                 vld_in;
        logic [SQ_W-1:0]      n_in;
        logic [REM_W-1:0]     rem_in;
        logic [ROOT_BITS-1:0] root_in;
        side_t                side_i;
        logic [1:0]           pair;
        logic [REM_W-1:0]     rem_sh;
        logic [REM_W-1:0]     trial;
        logic                 ge;

        if (i == 0) begin : g_first
            assign vld_in  = in_valid;
            assign n_in    = dist2;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_i  = side_in;
        end
        else begin : g_next
            assign vld_in  = vld_reg[i-1];
            assign n_in    = n_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign side_i  = side_reg[i-1];
        end

        if (K >= 0) begin : g_pair
            assign pair = n_in[2*K+1 -: 2];
        end
        else begin : g_zero
            assign pair = 2'b00;
        end

        assign rem_sh = {rem_in[REM_W-3:0], pair};
        assign trial  = {root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i]    <= n_in;
                rem_reg[i]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[i] <= {root_in[ROOT_BITS-2:0], ge};
                side_reg[i] <= side_i;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_BITS-1];
    assign root      = root_reg[ROOT_BITS-1];
    assign side_out  = side_reg[ROOT_BITS-1];

endmodule

// File: src/tsa_div.sv
`timescale 1ns / 1ps

module tsa_div
    import tsa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [ROOT_BITS-1:0]    root,
    input  side_t                   side_in,
    input  logic [R_W-1:0]          twirl_radius,
    output logic                    out_valid,
    output logic signed [ANG_W-1:0] ang,
    output side_t                   side_out
);

    logic signed [NUM_W:0] diff;
    logic signed [NUM_W:0] num;
    logic [NUM_W:0]        mag;
    logic [NUM_W:0]        lim;

    logic             vld_e_reg;
    logic [NUM_W-1:0] rem_e_reg;
    logic             neg_e_reg;
    logic             sat_e_reg;
    logic             zero_e_reg;
    side_t            side_e_reg;

    logic              vld_reg  [Q_BITS];
    logic [NUM_W-1:0]  rem_reg  [Q_BITS];
    logic [Q_BITS-1:0] q_reg    [Q_BITS];
    logic              neg_reg  [Q_BITS];
    logic              sat_reg  [Q_BITS];
    logic              zero_reg [Q_BITS];
    side_t             side_reg [Q_BITS];

    logic                    vld_o_reg;
    logic signed [ANG_W-1:0] ang_reg;
    side_t                   side_o_reg;

    // numerator 3*(r*2^F - d), split into sign and magnitude
    assign diff = $signed({{(NUM_W+1-R_W-FRAC_BITS){1'b0}}, twirl_radius, {FRAC_BITS{1'b0}}})
                - $signed({{(NUM_W+1-ROOT_BITS){1'b0}}, root});
    assign num  = (diff <<< 1) + diff;
    assign mag  = num[NUM_W] ? $unsigned(-num) : $unsigned(num);
    assign lim  = {{(NUM_W+1-R_W-Q_BITS){1'b0}}, twirl_radius, {Q_BITS{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_e_reg <= 1'b0;
        else if (en)
            vld_e_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_e_reg  <= mag[NUM_W-1:0];
            neg_e_reg  <= num[NUM_W];
            sat_e_reg  <= mag >= lim;
            zero_e_reg <= twirl_radius == '0;
            side_e_reg <= side_in;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < Q_BITS; j++) begin : g_stage
        localparam int B = Q_BITS - 1 - j;
        logic              vld_in;
        logic [NUM_W-1:0]  rem_in;
        logic [Q_BITS-1:0] q_in;
        logic              neg_in;
        logic              sat_in;
        logic              zero_in;
        side_t             side_i;
        logic [NUM_W-1:0]  dv;
        logic              ge;

        if (j == 0) begin : g_first
            assign vld_in  = vld_e_reg;
            assign rem_in  = rem_e_reg;
            assign q_in    = '0;
            assign neg_in  = neg_e_reg;
            assign sat_in  = sat_e_reg;
            assign zero_in = zero_e_reg;
            assign side_i  = side_e_reg;
        end
        else begin : g_next
            assign vld_in  = vld_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign neg_in  = neg_reg[j-1];
            assign sat_in  = sat_reg[j-1];
            assign zero_in = zero_reg[j-1];
            assign side_i  = side_reg[j-1];
        end

        assign dv = {{(NUM_W-R_W){1'b0}}, twirl_radius} << B;
        assign ge = rem_in >= dv;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= ge ? rem_in - dv : rem_in;
                q_reg[j]    <= {q_in[Q_BITS-2:0], ge};
                neg_reg[j]  <= neg_in;
                sat_reg[j]  <= sat_in;
                zero_reg[j] <= zero_in;
                side_reg[j] <= side_i;
            end
        end
    end

    // signed angle with the lower saturation at -3 rad
    logic signed [ANG_W-1:0] q_s;
    logic signed [ANG_W-1:0] ang_next;
    assign q_s = $signed({{(ANG_W-Q_BITS){1'b0}}, q_reg[Q_BITS-1]});

    always_comb
    begin
        if (zero_reg[Q_BITS-1])
            ang_next = '0;
        else if (sat_reg[Q_BITS-1])
            ang_next = -ANG_SAT;
        else if (neg_reg[Q_BITS-1])
            ang_next = (q_s > ANG_SAT) ? -ANG_SAT : -q_s;
        else
            ang_next = q_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_o_reg <= 1'b0;
        else if (en)
            vld_o_reg <= vld_reg[Q_BITS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg    <= ang_next;
            side_o_reg <= side_reg[Q_BITS-1];
        end
    end

    assign out_valid = vld_o_reg;
    assign ang       = ang_reg;
    assign side_out  = side_o_reg;

endmodule

// File: src/tsa_cordic.sv
`timescale 1ns / 1ps

module tsa_cordic
    import tsa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [ANG_W-1:0] ang,
    input  side_t                   side_in,
    output logic                    out_valid,
    output side_t                   side_out
);

    logic                    vld_q_reg;
    logic signed [ANG_W-1:0] ang_q_reg;
    side_t                   side_q_reg;
    logic signed [ANG_W-1:0] ang_q_next;
    side_t                   side_q_next;

    logic                    vld_reg  [CORDIC_STEPS];
    logic signed [ANG_W-1:0] ang_reg  [CORDIC_STEPS];
    side_t                   side_reg [CORDIC_STEPS];

    // quarter turn ahead of the micro-rotations
    always_comb
    begin
        side_q_next = side_in;
        ang_q_next  = ang;
        if (ang > HALF_PI)
        begin
            side_q_next.x = -side_in.y;
            side_q_next.y = side_in.x;
            ang_q_next    = ang - HALF_PI;
        end
        else if (ang < -HALF_PI)
        begin
            side_q_next.x = side_in.y;
            side_q_next.y = -side_in.x;
            ang_q_next    = ang + HALF_PI;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_q_reg <= 1'b0;
        else if (en)
            vld_q_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_q_reg <= side_q_next;
            ang_q_reg  <= ang_q_next;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        logic                    vld_in;
        logic signed [ANG_W-1:0] ang_in;
        side_t                   side_i;
        logic signed [XY_W-1:0]  xs;
        logic signed [XY_W-1:0]  ys;
        logic signed [ANG_W-1:0] ang_next;
        side_t                   side_next;

        if (i == 0) begin : g_first
            assign vld_in = vld_q_reg;
            assign ang_in = ang_q_reg;
            assign side_i = side_q_reg;
        end
        else begin : g_next
            assign vld_in = vld_reg[i-1];
            assign ang_in = ang_reg[i-1];
            assign side_i = side_reg[i-1];
        end

        assign xs = side_i.x >>> i;
        assign ys = side_i.y >>> i;

        always_comb
        begin
            side_next = side_i;
            if (!ang_in[ANG_W-1])
            begin
                side_next.x = side_i.x - ys;
                side_next.y = side_i.y + xs;
                ang_next    = ang_in - atan_step(i);
            end
            else
            begin
                side_next.x = side_i.x + ys;
                side_next.y = side_i.y - xs;
                ang_next    = ang_in + atan_step(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i] <= side_next;
                ang_reg[i]  <= ang_next;
            end
        end
    end

    assign out_valid = vld_reg[CORDIC_STEPS-1];
    assign side_out  = side_reg[CORDIC_STEPS-1];

endmodule

// File: tb/twirl_source_address_top_tb.sv
`timescale 1ns / 1ps

module twirl_source_address_top_tb;
    import tsa_pkg::*;

    localparam int LATENCY     = 73;
    localparam int NUM_RANDOM  = 1900;
    localparam int CYCLE_LIMIT = 400000;
    localparam int CMASK       = (1 << COORD_BITS) - 1;

    typedef struct packed {
        logic                  remapped;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [IDX_W-1:0]      idx;
    } source_t;

    // directed row: pixel plus an optional hand-typed expectation
    typedef struct {
        int      px;
        int      py;
        bit      typed;
        source_t want;
    } pixel_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [COORD_BITS-1:0] pixel_x = '0;
    logic [COORD_BITS-1:0] pixel_y = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  remapped;
    logic [COORD_BITS-1:0] source_x;
    logic [COORD_BITS-1:0] source_y;
    logic [IDX_W-1:0]      source_index;

    // register shadows
    longint unsigned img_w, img_h, cen_x, cen_y, rad, rad_sq;

    source_t    source_queue[$];
    pixel_row_t row_queue[$];
    int         fail_count = 0;
    int         cycle_count = 0;
    int         checked_count = 0;
    int         remap_count = 0;
    bit         hold_off = 1'b0;

    twirl_source_address_top i_dut (.*);

    always #6 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("twirl_source_address_top_tb: FAIL");
            $finish;
        end
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint trunc_q(longint v);
        if (v < 0)
            return -((-v) >>> FRAC_BITS);
        return v >>> FRAC_BITS;
    endfunction

    function automatic longint sqrt_q(longint unsigned n);
        longint unsigned rem_v, root_v, trial, pair;
        rem_v = 0;
        root_v = 0;
        for (int k = COORD_BITS; k >= -FRAC_BITS; k--)
        begin
            pair = (k >= 0) ? ((n >> (2 * k)) & 3) : 0;
            rem_v = (rem_v << 2) | pair;
            root_v = root_v << 1;
            trial = (root_v << 1) | 1;
            if (rem_v >= trial)
            begin
                rem_v -= trial;
                root_v |= 1;
            end
        end
        return longint'(root_v);
    endfunction

    // predicted source address for one pixel
    function automatic source_t twirl_source(longint unsigned px, longint unsigned py);
        source_t         s;
        longint          dx, dy, d, ang, x, y, t, half, xs, ys, a, nx, ny, r;
        longint unsigned dist2, sx, sy;
        bit              hit;
        dx = longint'(px) - longint'(cen_x);
        dy = longint'(py) - longint'(cen_y);
        dist2 = dx * dx + dy * dy;
        sx = px;
        sy = py;
        hit = 1'b0;
        if (dist2 <= rad_sq)
        begin
            d = sqrt_q(dist2);
            ang = 0;
            half = longint'(HALF_PI_Q30) >>> DSHIFT;
            if (rad != 0)
            begin
                r = longint'(rad);
                ang = (TWIRL_GAIN * ((r << FRAC_BITS) - d)) / r;
                if (ang < -(longint'(TWIRL_GAIN) << FRAC_BITS))
                    ang = -(longint'(TWIRL_GAIN) << FRAC_BITS);
            end
            x = floor_sh(dx * longint'(K_Q30), DSHIFT);
            y = floor_sh(dy * longint'(K_Q30), DSHIFT);
            if (ang > half)
            begin
                t = x; x = -y; y = t; ang -= half;
            end
            else if (ang < -half)
            begin
                t = x; x = y; y = -t; ang += half;
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                xs = floor_sh(x, i);
                ys = floor_sh(y, i);
                a = longint'(ATAN_Q30[i]) >>> DSHIFT;
                if (ang >= 0)
                begin
                    x -= ys; y += xs; ang -= a;
                end
                else
                begin
                    x += ys; y -= xs; ang += a;
                end
            end
            nx = trunc_q((longint'(cen_x) << FRAC_BITS) + x);
            ny = trunc_q((longint'(cen_y) << FRAC_BITS) + y);
            if (nx >= 0 && ny >= 0 && nx < longint'(img_w) && ny < longint'(img_h))
            begin
                hit = 1'b1;
                sx = longint'(nx);
                sy = longint'(ny);
            end
        end
        s.remapped = hit;
        s.sx = sx[COORD_BITS-1:0];
        s.sy = sy[COORD_BITS-1:0];
        s.idx = IDX_W'(sy * img_w + sx);
        return s;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WIDTH:  img_w = val & 32'h1FFF;
            REG_HEIGHT: img_h = val & 32'h1FFF;
            REG_CX:     cen_x = val & 32'hFFF;
            REG_CY:     cen_y = val & 32'hFFF;
            REG_RADIUS: rad = val & 32'h1FFF;
            REG_RSQ:    rad_sq = val & 32'h1FFFFFF;
            default:    ;
        endcase
    endtask

    task automatic set_geometry(input int w, input int h, input int cx, input int cy,
                                input int r, input int rsq);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_CX, cx);
        reg_write(REG_CY, cy);
        reg_write(REG_RADIUS, r);
        reg_write(REG_RSQ, rsq);
    endtask

    function automatic int short_or_long_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // send one pixel transfer and queue its expectation
    task automatic send_pixel(input int px, input int py,
                              input bit typed, input source_t want, input bit gaps);
        int gap;
        gap = gaps ? short_or_long_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_x <= COORD_BITS'(px);
        pixel_y <= COORD_BITS'(py);
        if (typed)
            source_queue = {source_queue, want};
        else
            source_queue = {source_queue,
                            twirl_source(longint'(px & CMASK), longint'(py & CMASK))};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (source_queue.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    // receiver stall, with an optional long hold-off
    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else
            begin
                n = short_or_long_gap();
                out_stall <= (n > 0);
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        source_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (source_queue.size() == 0)
            begin
                $error("unexpected source transfer");
                fail_count++;
            end
            else
            begin
                want = source_queue.pop_front();
                checked_count++;
                if (remapped)
                    remap_count++;
                if (remapped !== want.remapped)
                begin
                    $error("remapped exp %0d got %0d", want.remapped, remapped);
                    fail_count++;
                end
                if (source_x !== want.sx)
                begin
                    $error("source_x exp %0d got %0d", want.sx, source_x);
                    fail_count++;
                end
                if (source_y !== want.sy)
                begin
                    $error("source_y exp %0d got %0d", want.sy, source_y);
                    fail_count++;
                end
                if (source_index !== want.idx)
                begin
                    $error("source_index exp %0d got %0d", want.idx, source_index);
                    fail_count++;
                end
            end
        end
    end

    function automatic pixel_row_t mk(int px, int py);
        pixel_row_t r;
        r.px = px;
        r.py = py;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic pixel_row_t mk_typed(int px, int py, source_t w);
        pixel_row_t r;
        r = mk(px, py);
        r.typed = 1'b1;
        r.want = w;
        return r;
    endfunction

    initial
    begin
        pixel_row_t r;
        int         sel, w, h, cx, cy, rr, rsq;
        img_w = 1024; img_h = 1024; cen_x = 512; cen_y = 512;
        rad = 512; rad_sq = 262144;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table with reset geometry
        row_queue = {row_queue, mk_typed(0, 0, '{1'b0, 12'd0, 12'd0, 24'd0})};
        row_queue = {row_queue, mk_typed(4095, 4095,
                     '{1'b0, 12'd4095, 12'd4095, 24'(4095 * 1024 + 4095)})};
        row_queue = {row_queue,
                     mk_typed(0, 4095, '{1'b0, 12'd0, 12'd4095, 24'(4095 * 1024)})};
        row_queue = {row_queue, mk(512, 512)};
        row_queue = {row_queue, mk(1023, 512)};
        row_queue = {row_queue, mk(512, 0)};
        row_queue = {row_queue, mk(0, 512)};
        row_queue = {row_queue, mk(600, 700)};
        row_queue = {row_queue, mk(300, 400)};
        row_queue = {row_queue, mk(513, 512)};
        row_queue = {row_queue, mk(2730, 1365)};
        row_queue = {row_queue, mk(1365, 2730)};
        foreach (row_queue[i])
            send_pixel(row_queue[i].px, row_queue[i].py, row_queue[i].typed,
                       row_queue[i].want, 1'b0);
        drain();

        // zero radius, oversized radius squared saturates the angle
        set_geometry(4096, 4096, 2048, 2048, 0, 16777216);
        send_pixel(2048, 2048, 1'b0, '0, 1'b0);
        send_pixel(0, 0, 1'b0, '0, 1'b0);
        send_pixel(4095, 4095, 1'b0, '0, 1'b0);
        drain();
        set_geometry(4096, 4096, 2048, 2048, 1, 16777216);
        send_pixel(100, 3000, 1'b0, '0, 1'b0);
        send_pixel(4095, 0, 1'b0, '0, 1'b0);
        drain();
        // zero width and height: nothing remapped
        set_geometry(0, 0, 10, 10, 8, 64);
        send_pixel(10, 10, 1'b0, '{1'b0, 12'd10, 12'd10, 24'd0}, 1'b1);
        send_pixel(12, 9, 1'b0, '0, 1'b0);
        drain();
        // oversized width wraps the index
        set_geometry(8191, 8191, 4095, 4095, 8191, 33554431);
        send_pixel(4095, 4095, 1'b0, '0, 1'b0);
        send_pixel(0, 0, 1'b0, '0, 1'b0);
        send_pixel(4095, 0, 1'b0, '0, 1'b0);
        drain();

        // random phases with long receiver hold-off in the first
        for (int phase = 0; phase < 8; phase++)
        begin
            sel = $urandom_range(0, 3);
            w = (sel == 0) ? 4096 : $urandom_range(1, 4096);
            h = (sel == 0) ? 4096 : $urandom_range(1, 4096);
            cx = (sel == 1) ? 0 : $urandom_range(0, 4095);
            cy = (sel == 1) ? 4095 : $urandom_range(0, 4095);
            rr = (sel == 2) ? 4096 : $urandom_range(1, 2000);
            rsq = (sel == 3) ? $urandom_range(1, 16777216) : rr * rr;
            if (sel == 3 && $urandom_range(0, 1))
                rsq = 1;
            set_geometry(w, h, cx, cy, rr, rsq);
            if (phase == 0)
                hold_off = 1'b1;
            for (int n = 0; n < NUM_RANDOM / 8; n++)
            begin
                if ($urandom_range(0, 3) != 0)
                    send_pixel(cx + int'($urandom_range(0, 2 * rr)) - rr,
                               cy + int'($urandom_range(0, 2 * rr)) - rr, 1'b0, '0, 1'b1);
                else
                    send_pixel(int'($urandom), int'($urandom), 1'b0, '0, 1'b1);
            end
            drain();
        end

        if (source_queue.size() != 0)
        begin
            $error("%0d source transfers never arrived", source_queue.size());
            fail_count++;
        end
        $display("checked %0d source transfers, %0d remapped, over 13 register settings",
                 checked_count, remap_count);
        if (fail_count == 0)
            $display("twirl_source_address_top_tb: PASS");
        else
            $display("twirl_source_address_top_tb: FAIL");
        $finish;
    end

endmodule
